[hdl/cdd_pkg.sv]
package cdd_pkg;

    localparam int SERIAL_W = 23;
    localparam int COUNT_W  = 22;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_FIRST  = 2'd1;
    localparam logic [1:0] STATUS_BAD_SECOND = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for x below 43690
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    typedef struct packed {
        logic [13:0] year_first;
        logic [3:0]  month_first;
        logic [4:0]  day_first;
        logic [13:0] year_second;
        logic [3:0]  month_second;
        logic [4:0]  day_second;
    } t_date_in;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               first_is_later;
        logic [1:0]         status;
    } t_result;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // zero for month codes outside 1 to 12
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

[hdl/calendar_date_difference_top.sv]
// Days between two proleptic Gregorian dates. One date pair per clock is taken unless o_stall
// is high, and each transaction returns its result through a four-stage pipeline (reciprocal
// multiplies, date check and year sum, serial day number, compare and subtract); a stall on
// the output freezes only the stages that hold data, so empty stages keep filling. A date
// with year 0 or above MAX_YEAR, a bad month, day 0 or a day past the month's end gives
// status 1 for the first date or 2 for the second (the first wins), with a zero count.
module calendar_date_difference_top #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cdd_pkg::t_date_in i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output cdd_pkg::t_result  o_data
);

    logic [4:1] r_v;
    logic [4:1] adv;
    cdd_pkg::t_stage_en en;

    always_comb begin
        adv[4] = !r_v[4] || !i_stall;
        adv[3] = !r_v[3] || adv[4];
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        en.s1  = adv[1];
        en.s2  = adv[2];
        en.s3  = adv[3];
    end

    assign o_stall = !adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) r_v[1] <= i_valid;
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
        end
    end

    logic [cdd_pkg::SERIAL_W-1:0] serial_a;
    logic [cdd_pkg::SERIAL_W-1:0] serial_b;
    logic                         ok_a;
    logic                         ok_b;

    cdd_date_unit #(
        .MAX_YEAR (MAX_YEAR)
    ) u_date_first (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_year   (i_data.year_first),
        .i_month  (i_data.month_first),
        .i_day    (i_data.day_first),
        .o_serial (serial_a),
        .o_ok     (ok_a)
    );

    cdd_date_unit #(
        .MAX_YEAR (MAX_YEAR)
    ) u_date_second (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_year   (i_data.year_second),
        .i_month  (i_data.month_second),
        .i_day    (i_data.day_second),
        .o_serial (serial_b),
        .o_ok     (ok_b)
    );

    // stage 4: order, difference, saturation, status
    logic                         n_later;
    logic [cdd_pkg::SERIAL_W-1:0] n_diff;
    cdd_pkg::t_result             n_res;
    cdd_pkg::t_result             r_res;

    always_comb begin
        n_later = serial_a > serial_b;
        n_diff  = n_later ? (serial_a - serial_b) : (serial_b - serial_a);
        n_res   = '0;
        if (!ok_a) begin
            n_res.status = cdd_pkg::STATUS_BAD_FIRST;
        end else if (!ok_b) begin
            n_res.status = cdd_pkg::STATUS_BAD_SECOND;
        end else begin
            n_res.status         = cdd_pkg::STATUS_OK;
            n_res.first_is_later = n_later;
            n_res.day_count      = n_diff[cdd_pkg::SERIAL_W-1] ? cdd_pkg::COUNT_MAX
                                   : n_diff[cdd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v[4];
    assign o_data  = r_res;

endmodule

[hdl/cdd_date_unit.sv]
module cdd_date_unit #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                          i_clk,
    input  cdd_pkg::t_stage_en            i_en,
    input  logic [13:0]                   i_year,
    input  logic [3:0]                    i_month,
    input  logic [4:0]                    i_day,
    output logic [cdd_pkg::SERIAL_W-1:0]  o_serial,
    output logic                          o_ok
);

    localparam logic [16:0] YEAR_LIMIT = 17'(MAX_YEAR);

    // stage 1: reciprocal multiplies
    logic [13:0] n1_p;
    logic [11:0] n1_p4;
    logic [26:0] n1_prod_y;
    logic [24:0] n1_prod_p;
    logic [22:0] n1_m365;

    logic [13:0] r1_y;
    logic [3:0]  r1_m;
    logic [4:0]  r1_d;
    logic [9:0]  r1_qy;
    logic [7:0]  r1_qp;
    logic [11:0] r1_p4;
    logic [22:0] r1_m365;

    always_comb begin
        n1_p      = i_year - 14'd1;
        n1_p4     = n1_p[13:2];
        n1_prod_y = 27'(i_year) * 27'(cdd_pkg::DIV25_MUL);
        n1_prod_p = 25'(n1_p4) * 25'(cdd_pkg::DIV25_MUL);
        n1_m365   = 23'(n1_p) * 23'(cdd_pkg::DAYS_YEAR);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_y    <= i_year;
            r1_m    <= i_month;
            r1_d    <= i_day;
            r1_qy   <= n1_prod_y[26:cdd_pkg::DIV25_SHIFT];
            r1_qp   <= n1_prod_p[24:cdd_pkg::DIV25_SHIFT];
            r1_p4   <= n1_p4;
            r1_m365 <= n1_m365;
        end
    end

    // stage 2: leap year, date check, year part and day of year
    logic [14:0] n2_y25;
    logic        n2_mod25_zero;
    logic        n2_leap;
    logic [4:0]  n2_len;
    logic        n2_ok;
    logic [22:0] n2_yp;
    logic [8:0]  n2_doy;

    logic        r2_ok;
    logic [22:0] r2_yp;
    logic [8:0]  r2_doy;

    always_comb begin
        n2_y25        = {1'b0, r1_qy, 4'b0} + {2'b0, r1_qy, 3'b0} + {5'b0, r1_qy};
        n2_mod25_zero = (n2_y25 == {1'b0, r1_y});
        n2_leap       = (r1_y[1:0] == 2'b00) && (!n2_mod25_zero || (r1_y[3:0] == 4'b0000));
        n2_len        = cdd_pkg::month_len(r1_m);
        if (r1_m == 4'd2 && n2_leap) begin
            n2_len = 5'd29;
        end
        n2_ok  = (r1_y != 14'd0) && ({3'b0, r1_y} <= YEAR_LIMIT) && (n2_len != 5'd0)
                 && (r1_d != 5'd0) && (r1_d <= n2_len);
        n2_yp  = r1_m365 + 23'(r1_p4) - 23'(r1_qp) + 23'(r1_qp[7:2]);
        n2_doy = cdd_pkg::days_before(r1_m) + 9'(r1_d)
                 + 9'((r1_m > 4'd2) && n2_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_ok  <= n2_ok;
            r2_yp  <= n2_yp;
            r2_doy <= n2_doy;
        end
    end

    // stage 3: serial day number
    logic [cdd_pkg::SERIAL_W-1:0] r3_serial;
    logic                         r3_ok;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_serial <= r2_yp + 23'(r2_doy);
            r3_ok     <= r2_ok;
        end
    end

    assign o_serial = r3_serial;
    assign o_ok     = r3_ok;

endmodule

[hdl/cdd_checker.sv]
module cdd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input cdd_pkg::t_result  o_data
);

    // an invalid date carries no count and no order
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != cdd_pkg::STATUS_OK)
        |-> (o_data.day_count == '0) && !o_data.first_is_later)
        else $error("invalid date with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == cdd_pkg::STATUS_OK)
                 || (o_data.status == cdd_pkg::STATUS_BAD_FIRST)
                 || (o_data.status == cdd_pkg::STATUS_BAD_SECOND))
        else $error("unknown status code");

    a_later_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.first_is_later |-> (o_data.day_count != '0))
        else $error("later date with zero distance");

    // input backpressure only when the output side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled transaction changed");

endmodule

bind calendar_date_difference_top cdd_checker u_cdd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

[tb/sv/date_span_checker.sv]
module date_span_checker
    import cdd_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_date_in i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_result  i_out_data,
    output int       o_fail_count,
    output int       o_pending
);

    t_result spans_due[$];
    t_result want;
    int      fails;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        return y >= 1 && y <= MAX_YEAR && d >= 1 && d <= days_in_month(y, m);
    endfunction

    function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + d;
        for (int unsigned k = 1; k < m; k++) begin
            n += days_in_month(y, k);
        end
        return n;
    endfunction

    function automatic t_result expected_span(input t_date_in x);
        t_result     r;
        int unsigned a;
        int unsigned b;
        int unsigned span;
        r = '0;
        if (!date_valid(x.year_first, x.month_first, x.day_first)) begin
            r.status = STATUS_BAD_FIRST;
        end else if (!date_valid(x.year_second, x.month_second, x.day_second)) begin
            r.status = STATUS_BAD_SECOND;
        end else begin
            a = day_number(x.year_first, x.month_first, x.day_first);
            b = day_number(x.year_second, x.month_second, x.day_second);
            r.first_is_later = a > b;
            span = (a > b) ? a - b : b - a;
            if (span > COUNT_MAX) begin
                span = COUNT_MAX;
            end
            r.day_count = span[COUNT_W-1:0];
            r.status    = STATUS_OK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spans_due.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                spans_due.push_back(expected_span(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (spans_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, i_out_data);
                    fails++;
                end else begin
                    want = spans_due.pop_front();
                    if (i_out_data.day_count !== want.day_count) begin
                        $display("%0t: day_count expected %0d actual %0d",
                                 $time, want.day_count, i_out_data.day_count);
                        fails++;
                    end
                    if (i_out_data.first_is_later !== want.first_is_later) begin
                        $display("%0t: first_is_later expected %0d actual %0d",
                                 $time, want.first_is_later, i_out_data.first_is_later);
                        fails++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_out_data.status);
                        fails++;
                    end
                end
            end
            o_pending    <= spans_due.size();
            o_fail_count <= fails;
        end
    end

endmodule

[tb/sv/tb_calendar_date_difference_top.sv]
module tb_calendar_date_difference_top;
    import cdd_pkg::*;

    localparam int unsigned MAX_YEAR   = 9999;
    localparam int          RANDOM_N   = 1000;
    localparam int          QUIET_FROM = 850;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_date_in i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_result  o_data;

    int fail_count;
    int results_due;
    int sent_count = 0;
    int gap_pct    = 0;
    bit quiet      = 1'b0;
    bit hold_done  = 1'b0;

    always #2 i_clk = ~i_clk;

    calendar_date_difference_top #(
        .MAX_YEAR(MAX_YEAR)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    date_span_checker #(
        .MAX_YEAR(MAX_YEAR)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .o_fail_count(fail_count),
        .o_pending   (results_due)
    );

    function automatic t_date_in pack_dates(input int unsigned y1, input int unsigned m1,
                                            input int unsigned d1, input int unsigned y2,
                                            input int unsigned m2, input int unsigned d2);
        t_date_in x;
        x.year_first   = 14'(y1);
        x.month_first  = 4'(m1);
        x.day_first    = 5'(d1);
        x.year_second  = 14'(y2);
        x.month_second = 4'(m2);
        x.day_second   = 5'(d2);
        return x;
    endfunction

    // mostly well-formed dates, the rest noise over the full field widths
    function automatic void pick_date(output int unsigned y, output int unsigned m,
                                      output int unsigned d);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                y = $urandom_range(1, MAX_YEAR);
            end else if (roll < 85) begin
                y = $urandom_range(1, MAX_YEAR / 100) * 100;
            end else begin
                y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(MAX_YEAR - 2,
                                                                                    MAX_YEAR);
            end
            m = $urandom_range(1, 12);
            d = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 28) : $urandom_range(29, 31);
        end
    endfunction

    task automatic send_pair(input t_date_in x);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    // receiver side: random stall bursts, one long hold-off, none near the end
    initial begin
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch   = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stretch == 0) begin
                stretch   = 64;
                stall_pct = $urandom_range(0, 2) * 15;
            end
            stretch--;
            if (!quiet && !hold_done && sent_count >= 300) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned y1;
        int unsigned m1;
        int unsigned d1;
        int unsigned y2;
        int unsigned m2;
        int unsigned d2;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 10;
        send_pair(pack_dates(1, 1, 1, 1, 1, 1));
        send_pair(pack_dates(1, 1, 1, 9999, 12, 31));
        send_pair(pack_dates(9999, 12, 31, 1, 1, 1));
        send_pair(pack_dates(2000, 2, 29, 2000, 3, 1));
        send_pair(pack_dates(1900, 2, 29, 1900, 3, 1));
        send_pair(pack_dates(2024, 2, 29, 2023, 2, 29));
        send_pair(pack_dates(2100, 2, 28, 2100, 3, 1));
        send_pair(pack_dates(2004, 3, 1, 2004, 2, 28));
        send_pair(pack_dates(0, 6, 15, 2020, 6, 15));
        send_pair(pack_dates(2020, 6, 15, 10000, 6, 15));
        send_pair(pack_dates(16383, 15, 31, 16383, 15, 31));
        send_pair(pack_dates(2020, 0, 10, 2020, 1, 10));
        send_pair(pack_dates(2020, 1, 10, 2020, 13, 10));
        send_pair(pack_dates(2020, 15, 1, 1, 1, 1));
        send_pair(pack_dates(2020, 5, 0, 2020, 5, 1));
        send_pair(pack_dates(2020, 4, 31, 2020, 4, 30));
        send_pair(pack_dates(2020, 12, 31, 2021, 1, 1));
        send_pair(pack_dates(2021, 1, 1, 2020, 12, 31));
        send_pair(pack_dates(1600, 2, 29, 1700, 2, 28));
        send_pair(pack_dates(0, 0, 0, 0, 0, 0));
        send_pair(pack_dates(2020, 6, 15, 2020, 6, 15));
        send_pair(pack_dates(9999, 2, 28, 9999, 2, 29));

        for (int i = 0; i < RANDOM_N; i++) begin
            if (i == RANDOM_N / 2) begin
                drain_results();
            end
            if (i == QUIET_FROM) begin
                quiet = 1'b1;
            end
            if (quiet) begin
                gap_pct = 0;
            end else if (i % 40 == 0) begin
                gap_pct = $urandom_range(0, 2) * 12;
            end
            pick_date(y1, m1, d1);
            case ($urandom_range(0, 6))
                0: begin
                    y2 = y1;
                    m2 = m1;
                    d2 = d1;
                end
                1: begin
                    y2 = y1;
                    m2 = m1;
                    d2 = $urandom_range(1, 31);
                end
                default: pick_date(y2, m2, d2);
            endcase
            send_pair(pack_dates(y1, m1, d1, y2, m2, d2));
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
